FILE: design/fbfl_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the fixed-block free-list allocator.
// No dependencies; imported by fbfl_link_store and the top level.
package fbfl_pkg;

    localparam int DEF_MAX_BLOCKS   = 64;
    localparam int RST_BLOCK_COUNT  = 64;
    localparam int RST_BLOCK_BYTES  = 32;
    localparam int MIN_BLOCK_BYTES  = 4;
    localparam int MAX_BLOCK_BYTES  = 4096;

    localparam int CFG_DATA_W       = 13;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OOM      = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    // register indexes
    localparam logic REG_BLOCK_COUNT = 1'b0;
    localparam logic REG_BLOCK_BYTES = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [5:0] free_index;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  block_index;
        logic [17:0] block_offset;
        logic [6:0]  used_count;
    } t_out_beat;

    // control from the sequencer to the link store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } t_link_ctl;

endpackage

FILE: design/fbfl_link_store.sv
`timescale 1ns / 1ps
// Link memory of the free list: one successor code per block, registered read.
// Depends on fbfl_pkg (t_link_ctl, DEF_MAX_BLOCKS).
module fbfl_link_store
    import fbfl_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_link_ctl                       i_ctl,
    input  logic [$clog2(MAX_BLOCKS)-1:0]   i_rd_addr,
    input  logic [$clog2(MAX_BLOCKS)-1:0]   i_wr_addr,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0] i_wr_data,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0] i_block_count,
    output logic [$clog2(MAX_BLOCKS+1)-1:0] o_rd_link
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int LW = $clog2(MAX_BLOCKS + 1);
    localparam logic [LW-1:0] END_MARK = LW'(MAX_BLOCKS);

    logic [LW-1:0]         r_mem [MAX_BLOCKS];
    logic [LW-1:0]         r_rdata;
    logic [IW-1:0]         r_rd_addr;
    // entry written since the last chain rebuild; otherwise it reads as the sequential link
    logic [MAX_BLOCKS-1:0] r_vld;
    logic [LW-1:0]         seq_link;
    logic [LW-1:0]         nxt;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rdata   <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_vld <= '0;
        end else if (i_ctl.wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_comb begin
        nxt      = LW'(r_rd_addr) + LW'(1);
        seq_link = (nxt < i_block_count) ? nxt : END_MARK;
    end

    assign o_rd_link = r_vld[r_rd_addr] ? r_rdata : seq_link;

endmodule

FILE: design/fixed_block_free_list_allocator_unit.sv
`timescale 1ns / 1ps
// Top level of the fixed-block free-list allocator: sequencer, head/count registers,
// result register. Depends on fbfl_pkg and fbfl_link_store.
//
//  channel | direction | handshake                  | beat
//  in      | input     | i_in_valid / o_in_stall    | t_in_beat  (cmd, free_index)
//  out     | output    | o_out_valid / i_out_stall  | t_out_beat (status, index, offset, used)
//  cfg     | input     | i_cfg_we, no wait          | i_cfg_index, i_cfg_data
//
// Each command is accepted in S_IDLE, where the accept edge issues the link read at the head;
// the finish edge consumes the registered read data and, for a free, writes the link back.
// Commands are taken one at a time; a stalled result sits in the output register
// while the next command is accepted and read, and holds that command's finish.
// Reset and config writes rebuild the chain at once (per-entry valid bits); no sweep.
module fixed_block_free_list_allocator_unit
    import fbfl_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_data,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int LW = $clog2(MAX_BLOCKS + 1);
    localparam logic [LW-1:0] END_MARK  = LW'(MAX_BLOCKS);
    localparam logic [LW-1:0] RST_COUNT =
        LW'((MAX_BLOCKS < RST_BLOCK_COUNT) ? MAX_BLOCKS : RST_BLOCK_COUNT);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                  r_state, n_state;
    logic [LW-1:0]         r_head, n_head;
    logic [LW-1:0]         r_used, n_used;
    logic [LW-1:0]         r_block_count, n_block_count;
    logic [CFG_DATA_W-1:0] r_block_bytes, n_block_bytes;
    logic                  r_cmd;
    logic [5:0]            r_idx;
    logic                  r_out_valid, n_out_valid;
    t_out_beat             r_out, n_out;

    t_link_ctl             link_ctl;
    logic [IW-1:0]         rd_addr;
    logic [LW-1:0]         rd_link;
    logic [LW-1:0]         link;
    logic                  in_accept;
    logic                  finish;
    logic                  lazy;
    logic                  free_ok;
    logic [IW+CFG_DATA_W-1:0] offset;
    logic [6:0]            cfg_cnt;
    logic [CFG_DATA_W-1:0] cfg_bytes;

    fbfl_link_store #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_link (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (link_ctl),
        .i_rd_addr     (rd_addr),
        .i_wr_addr     (IW'(r_idx)),
        .i_wr_data     (r_head),
        .i_block_count (r_block_count),
        .o_rd_link     (rd_link)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign finish     = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign rd_addr    = (r_head == END_MARK) ? '0 : IW'(r_head);

    // alloc at head 0 with nothing in use: chain is rebuilt before popping
    assign lazy    = (r_cmd == CMD_ALLOC) && (r_head == '0) && (r_used == '0);
    assign link    = lazy ? ((LW'(1) < r_block_count) ? LW'(1) : END_MARK) : rd_link;
    assign free_ok = (32'(r_idx) < 32'(r_block_count)) && (32'(r_idx) < MAX_BLOCKS)
                     && (r_used != '0);
    assign offset  = (IW+CFG_DATA_W)'(IW'(r_head)) * (IW+CFG_DATA_W)'(r_block_bytes);

    always_comb begin
        link_ctl.rd_en = in_accept;
        link_ctl.wr_en = finish && (r_cmd == CMD_FREE) && free_ok;
        link_ctl.clear = i_cfg_we || (finish && lazy);
    end

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_used        = r_used;
        n_block_count = r_block_count;
        n_block_bytes = r_block_bytes;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out         = r_out;
        cfg_cnt       = i_cfg_data[6:0];
        cfg_bytes     = i_cfg_data;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (finish) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out        = '0;
                    if (r_cmd == CMD_ALLOC) begin
                        if (!lazy && ((r_head == END_MARK) || (r_used >= r_block_count))) begin
                            n_out.status = ST_OOM;
                        end else begin
                            n_head             = link;
                            n_used             = r_used + LW'(1);
                            n_out.status       = ST_OK;
                            n_out.block_index  = 6'(r_head);
                            n_out.block_offset = 18'(offset);
                        end
                    end else begin
                        if (free_ok) begin
                            n_head = LW'(r_idx);
                            n_used = r_used - LW'(1);
                        end else begin
                            n_out.status = ST_BAD_FREE;
                        end
                    end
                    n_out.used_count = 7'(n_used);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BLOCK_COUNT: begin
                    if (cfg_cnt == 7'd0) begin
                        n_block_count = LW'(1);
                    end else if (32'(cfg_cnt) > MAX_BLOCKS) begin
                        n_block_count = END_MARK;
                    end else begin
                        n_block_count = LW'(cfg_cnt);
                    end
                end
                REG_BLOCK_BYTES: begin
                    if (32'(cfg_bytes) < MIN_BLOCK_BYTES) begin
                        n_block_bytes = CFG_DATA_W'(MIN_BLOCK_BYTES);
                    end else if (32'(cfg_bytes) > MAX_BLOCK_BYTES) begin
                        n_block_bytes = CFG_DATA_W'(MAX_BLOCK_BYTES);
                    end else begin
                        n_block_bytes = cfg_bytes;
                    end
                end
                default: begin
                    n_block_count = r_block_count;
                end
            endcase
            n_head = '0;
            n_used = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_head        <= '0;
            r_used        <= '0;
            r_block_count <= RST_COUNT;
            r_block_bytes <= CFG_DATA_W'(RST_BLOCK_BYTES);
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_head        <= n_head;
            r_used        <= n_used;
            r_block_count <= n_block_count;
            r_block_bytes <= n_block_bytes;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_accept) begin
            r_cmd <= i_in_data.cmd;
            r_idx <= i_in_data.free_index;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_used_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= r_block_count)
        else $error("used count above block count");

    a_head_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == END_MARK) || (r_head < r_block_count))
        else $error("free-list head outside pool");

    a_result_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result beat without a finished command");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_EXEC))
        else $error("accepted command not executed");
`endif

endmodule
